// ===== rtl/crout_pkg.sv =====
// Shared constants, types and helper functions of the Crout LU block.
package crout_pkg;

   localparam int MAX_ORDER = 64;
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int IDX_W     = $clog2(MAX_ORDER);
   localparam int CNT_W     = IDX_W + 1;
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
   localparam int ACC_W     = 64;
   localparam int DIV_W     = DATA_W + FRAC_BITS;
   localparam int DCNT_W    = $clog2(DIV_W);

   localparam logic signed [ACC_W-1:0] MAX_VAL = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] MIN_VAL = -ACC_W'(64'sd2147483648);
   localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [DATA_W-1:0] ONE_VAL = DATA_W'(1) <<< FRAC_BITS;

   // Command codes of an input word.
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Status codes of a result word.
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_ZERO_PIVOT = 2'd1;
   localparam logic [1:0] ST_SATURATED  = 2'd2;
   localparam logic [1:0] ST_OUTSIDE    = 2'd3;

   typedef struct packed {
      logic                     sat;
      logic signed [DATA_W-1:0] val;
   } clip_type;

   // Clip a wide value to 32 bits and report whether it clipped.
   function automatic clip_type clip32(input logic signed [ACC_W-1:0] x);
      clip_type r;
      r.sat = (x > MAX_VAL) || (x < MIN_VAL);
      if (x > MAX_VAL) begin
         r.val = MAX_VAL[DATA_W-1:0];
      end else if (x < MIN_VAL) begin
         r.val = MIN_VAL[DATA_W-1:0];
      end else begin
         r.val = x[DATA_W-1:0];
      end
      return r;
   endfunction

   // Store address of an entry, row major.
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
      return {r, c};
   endfunction

   function automatic logic [1:0] flag_status(input logic zp, input logic sat);
      if (zp) begin
         return ST_ZERO_PIVOT;
      end else if (sat) begin
         return ST_SATURATED;
      end
      return ST_OK;
   endfunction

endpackage

// ===== rtl/crout_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module crout_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/crout_lu_decomposition.sv =====
// Top level of the Crout LU factorization block with its sequencer.
//
// Channel  Direction  Handshake             Payload
// req      in         req_tvalid/tready     tdata: row, col, value; tuser: command, select
// rsp      out        rsp_tvalid/tready     tdata: read value; tuser: status
// csr      in         csr_wr_en             csr_wr_data: matrix order
//
// A write is stored when taken and a read passes through S_READ, each
// followed by its result word. A start runs one shared multiplier and
// accumulator over every product of the factorization: S_FETCH_A,
// S_FETCH_B, S_MUL and S_ACC per product, S_FETCH_T and S_UPDATE per
// entry, and a bit-serial divider and a store per nonzero-pivot U entry.
// Reset is synchronous, clears the flags and control and sets the order to 64.
// The block takes no word while busy or while a result waits to be taken.
module crout_lu_decomposition (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // row_index, col_index, entry_value, zero fill
   input  logic [2:0]  req_tuser,   // command, factor_select
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_value
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data  // size_in_use
);
   import crout_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_READ    = 10'b00_0000_0010,
      S_FETCH_A = 10'b00_0000_0100,
      S_FETCH_B = 10'b00_0000_1000,
      S_MUL     = 10'b00_0001_0000,
      S_ACC     = 10'b00_0010_0000,
      S_FETCH_T = 10'b00_0100_0000,
      S_UPDATE  = 10'b00_1000_0000,
      S_DIVIDE  = 10'b01_0000_0000,
      S_STORE_Q = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [6:0]               size_ff;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [CNT_W-1:0]         i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic                     upper_ff, upper_in;
   logic                     zp_ff, zp_in, sat_ff, sat_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [DATA_W-1:0] opa_ff, opa_in;
   logic signed [ACC_W-1:0]  prod_ff, prod_in;
   logic signed [DATA_W-1:0] pivot_ff, pivot_in;
   logic [DIV_W-1:0]         dvd_ff, dvd_in;
   logic [DATA_W-1:0]        dvs_ff, dvs_in, rem_ff, rem_in;
   logic                     neg_ff, neg_in;
   logic [DCNT_W-1:0]        dcnt_ff, dcnt_in;
   logic                     use_mem_ff, use_mem_in, one_ff, one_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;

   // Input word fields.
   logic [1:0]         cmd;
   logic [IDX_W-1:0]   row_idx, col_idx;
   logic [DATA_W-1:0]  entry_val;
   logic               fsel, accept, in_range;
   logic [CNT_W-1:0]   order_now;

   // Datapath helpers.
   logic signed [ACC_W-1:0] rounded, diff, qsigned;
   logic [DIV_W:0]          qwide;
   clip_type                diff_clip, q_clip;
   logic [DATA_W:0]         rem_sh;
   logic [DATA_W-1:0]       num_mag, piv_mag;
   logic [IDX_W-1:0]        ii, jj, kk;
   logic [CNT_W-1:0]        i_next;

   assign cmd       = req_tuser[1:0];
   assign fsel      = req_tuser[2];
   assign row_idx   = req_tdata[IDX_W-1:0];
   assign col_idx   = req_tdata[2*IDX_W-1:IDX_W];
   assign entry_val = req_tdata[2*IDX_W+DATA_W-1:2*IDX_W];

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // Effective order: zero acts as one, above the maximum acts as the maximum.
   always_comb begin
      if (size_ff == '0) begin
         order_now = CNT_W'(1);
      end else if ({1'b0, size_ff} > 8'(MAX_ORDER)) begin
         order_now = CNT_W'(MAX_ORDER);
      end else begin
         order_now = CNT_W'(size_ff);
      end
   end

   assign in_range = ({1'b0, row_idx} < order_now) && ({1'b0, col_idx} < order_now);

   assign ii = i_ff[IDX_W-1:0];
   assign jj = j_ff[IDX_W-1:0];
   assign kk = k_ff[IDX_W-1:0];

   // Shared arithmetic: rounded product, update difference, divider step.
   assign rounded   = (prod_ff + ROUND_C) >>> FRAC_BITS;
   assign diff      = ACC_W'($signed(ram_rdata)) - acc_ff;
   assign diff_clip = clip32(diff);
   assign num_mag   = diff_clip.val[DATA_W-1] ? (~diff_clip.val + 1'b1) : diff_clip.val;
   assign piv_mag   = pivot_ff[DATA_W-1] ? (~pivot_ff + 1'b1) : pivot_ff;
   assign rem_sh    = {rem_ff, dvd_ff[DIV_W-1]};
   assign qwide     = {1'b0, dvd_ff};
   assign qsigned   = neg_ff ? -ACC_W'($signed(qwide)) : ACC_W'($signed(qwide));
   assign q_clip    = clip32(qsigned);

   crout_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Sequencer and next-state logic.
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      upper_in      = upper_ff;
      zp_in         = zp_ff;
      sat_in        = sat_ff;
      acc_in        = acc_ff;
      opa_in        = opa_ff;
      prod_in       = prod_ff;
      pivot_in      = pivot_ff;
      dvd_in        = dvd_ff;
      dvs_in        = dvs_ff;
      rem_in        = rem_ff;
      neg_in        = neg_ff;
      dcnt_in       = dcnt_ff;
      use_mem_in    = use_mem_ff;
      one_in        = one_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = upper_ff ? cell_addr(ii, jj) : cell_addr(jj, ii);
      ram_wdata     = diff_clip.val;
      ram_raddr     = cell_addr(row_idx, col_idx);
      i_next        = i_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_data_in   = '0;
               rsp_status_in = flag_status(zp_ff, sat_ff);
               if (cmd == CMD_START) begin
                  n_in     = order_now;
                  i_in     = '0;
                  j_in     = '0;
                  k_in     = '0;
                  upper_in = 1'b0;
                  zp_in    = 1'b0;
                  sat_in   = 1'b0;
                  acc_in   = '0;
                  state_in = S_FETCH_T;
               end else if ((cmd inside {CMD_WRITE, CMD_READ}) && !in_range) begin
                  rsp_status_in = ST_OUTSIDE;
                  rsp_valid_in  = 1'b1;
               end else if (cmd == CMD_WRITE) begin
                  ram_we       = 1'b1;
                  ram_waddr    = cell_addr(row_idx, col_idx);
                  ram_wdata    = entry_val;
                  rsp_valid_in = 1'b1;
               end else if (cmd == CMD_READ) begin
                  use_mem_in = fsel ? (row_idx < col_idx) : (row_idx >= col_idx);
                  one_in     = fsel && (row_idx == col_idx);
                  state_in   = S_READ;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_READ: begin
            rsp_data_in  = use_mem_ff ? ram_rdata : (one_ff ? ONE_VAL : '0);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_FETCH_A: begin
            ram_raddr = upper_ff ? cell_addr(ii, kk) : cell_addr(jj, kk);
            state_in  = S_FETCH_B;
         end
         S_FETCH_B: begin
            ram_raddr = upper_ff ? cell_addr(kk, jj) : cell_addr(kk, ii);
            opa_in    = ram_rdata;
            state_in  = S_MUL;
         end
         S_MUL: begin
            prod_in  = ACC_W'(opa_ff) * ACC_W'($signed(ram_rdata));
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in   = acc_ff + rounded;
            k_in     = k_ff + 1'b1;
            state_in = (k_ff + 1'b1 < i_ff) ? S_FETCH_A : S_FETCH_T;
         end
         S_FETCH_T: begin
            ram_raddr = upper_ff ? cell_addr(ii, jj) : cell_addr(jj, ii);
            state_in  = S_UPDATE;
         end
         S_UPDATE: begin
            sat_in = sat_ff || diff_clip.sat;
            if (!upper_ff) begin
               ram_we = 1'b1;
               if (j_ff == i_ff) begin
                  pivot_in = diff_clip.val;
                  zp_in    = zp_ff || (diff_clip.val == '0);
               end
            end else if (pivot_ff == '0) begin
               ram_we    = 1'b1;
               ram_wdata = '0;
            end else begin
               dvd_in   = {num_mag, FRAC_BITS'(0)};
               dvs_in   = piv_mag;
               rem_in   = '0;
               neg_in   = diff_clip.val[DATA_W-1] ^ pivot_ff[DATA_W-1];
               dcnt_in  = '0;
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            // One restoring division step per cycle, quotient shifts into dvd.
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = rem_sh[DATA_W-1:0] - dvs_ff;
               dvd_in = {dvd_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DATA_W-1:0];
               dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(DIV_W - 1)) begin
               state_in = S_STORE_Q;
            end
         end
         S_STORE_Q: begin
            ram_we    = 1'b1;
            ram_wdata = q_clip.val;
            sat_in    = sat_ff || q_clip.sat;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Step to the next entry once the current one is stored.
      if ((state_ff == S_UPDATE && (!upper_ff || pivot_ff == '0)) ||
          state_ff == S_STORE_Q) begin
         k_in   = '0;
         acc_in = '0;
         if (j_ff + 1'b1 < n_ff) begin
            j_in   = j_ff + 1'b1;
            i_next = i_ff;
         end else if (!upper_ff && (i_ff + 1'b1 < n_ff)) begin
            upper_in = 1'b1;
            j_in     = i_ff + 1'b1;
            i_next   = i_ff;
         end else if (upper_ff) begin
            upper_in = 1'b0;
            i_next   = i_ff + 1'b1;
            i_in     = i_next;
            j_in     = i_next;
         end else begin
            i_next = n_ff;
         end
         if (i_next == n_ff) begin
            state_in      = S_IDLE;
            rsp_data_in   = '0;
            rsp_status_in = flag_status(zp_in, sat_in);
            rsp_valid_in  = 1'b1;
         end else begin
            state_in = (i_next == '0) ? S_FETCH_T : S_FETCH_A;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= 7'd64;
         zp_ff        <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         zp_ff        <= zp_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
      end
   end

   // Datapath and loop registers.
   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      upper_ff      <= upper_in;
      acc_ff        <= acc_in;
      opa_ff        <= opa_in;
      prod_ff       <= prod_in;
      pivot_ff      <= pivot_in;
      dvd_ff        <= dvd_in;
      dvs_ff        <= dvs_in;
      rem_ff        <= rem_in;
      neg_ff        <= neg_in;
      dcnt_ff       <= dcnt_in;
      use_mem_ff    <= use_mem_in;
      one_ff        <= one_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   // A start never answers in the cycle after it is taken.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == CMD_START) |=> !rsp_tvalid)
      else $error("start answered too early");

   // The divider only runs against a nonzero pivot.
   a_div_pivot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE) |-> (pivot_ff != '0))
      else $error("division by zero pivot");

   // Product fetches stay below the current diagonal index.
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH_A) |-> (k_ff < i_ff && i_ff < n_ff))
      else $error("inner index out of range");

endmodule

// ===== tb/tb_crout_lu_decomposition.sv =====
// Self-checking testbench for the Crout LU factorization block.
module tb_crout_lu_decomposition;
   import crout_pkg::*;

   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam int LIMIT_CYCLES = 1500000;
   localparam int ITEMS_WANTED = 1150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // row_index, col_index, entry_value, zero fill
   logic [2:0]  req_tuser = '0;   // command, factor_select
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // read_value
   logic [1:0]  rsp_tuser;        // status
   logic        csr_wr_en = 1'b0;
   logic [6:0]  csr_wr_data = '0; // size_in_use

   crout_lu_decomposition u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   typedef struct {
      logic [31:0] data;
      logic [1:0]  status;
   } rsp_word_type;

   typedef struct {
      logic [1:0]  cmd;
      int          row;
      int          col;
      logic [31:0] value;
      bit          sel;
      bit          typed;
      logic [31:0] exp_data;
      logic [1:0]  exp_status;
   } dir_row_type;

   // Predictor state: matrix, flags and order register.
   int          lu_mat [0:4095];
   bit          lu_written [0:4095];
   bit          pivot_zero;
   bit          clipped;
   logic [6:0]  order_reg = 7'd64;

   rsp_word_type pending_rsp_q [$];
   int          error_count = 0;
   int          item_count = 0;
   int          hold_cycles = 0;
   int          cycle_count = 0;

   // Clock and watchdog.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb_crout_lu_decomposition: FAIL");
         $finish;
      end
   end

   // Arithmetic of the factorization, at full precision.
   function automatic longint round_prod(int a, int b);
      longint p;
      p = longint'(a) * longint'(b) + (64'sd1 <<< (FRAC_BITS - 1));
      return p >>> FRAC_BITS;
   endfunction

   function automatic int sat_word(longint x);
      if (x > 64'sd2147483647) begin
         clipped = 1'b1;
         return 32'h7FFFFFFF;
      end
      if (x < -64'sd2147483648) begin
         clipped = 1'b1;
         return 32'h80000000;
      end
      return int'(x);
   endfunction

   function automatic int active_order();
      if (order_reg == 0) return 1;
      if (order_reg > MAX_ORDER) return MAX_ORDER;
      return int'(order_reg);
   endfunction

   function automatic bit block_written(int n);
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++)
            if (!lu_written[r * 64 + c]) return 1'b0;
      return 1'b1;
   endfunction

   // In-place factorization: column of L, then row of unit-diagonal U.
   task automatic factor_block(int n);
      longint acc;
      int     piv;
      int     num;
      pivot_zero = 1'b0;
      clipped = 1'b0;
      for (int i = 0; i < n; i++) begin
         for (int j = i; j < n; j++) begin
            acc = 0;
            for (int k = 0; k < i; k++)
               acc += round_prod(lu_mat[j * 64 + k], lu_mat[k * 64 + i]);
            lu_mat[j * 64 + i] = sat_word(longint'(lu_mat[j * 64 + i]) - acc);
         end
         piv = lu_mat[i * 65];
         if (piv == 0) pivot_zero = 1'b1;
         for (int j = i + 1; j < n; j++) begin
            acc = 0;
            for (int k = 0; k < i; k++)
               acc += round_prod(lu_mat[i * 64 + k], lu_mat[k * 64 + j]);
            num = sat_word(longint'(lu_mat[i * 64 + j]) - acc);
            if (piv == 0) begin
               lu_mat[i * 64 + j] = 0;
            end else begin
               lu_mat[i * 64 + j] = sat_word((longint'(num) <<< FRAC_BITS) / longint'(piv));
            end
         end
      end
   endtask

   function automatic logic [1:0] flags_now();
      if (pivot_zero) return ST_ZERO_PIVOT;
      if (clipped) return ST_SATURATED;
      return ST_OK;
   endfunction

   // Expected result word for one accepted command.
   task automatic lu_predict(logic [1:0] cmd, int r, int c, logic [31:0] v, bit sel,
                             output rsp_word_type w);
      int n;
      bit in_range;
      n = active_order();
      in_range = (r < n) && (c < n);
      w.data = '0;
      if (cmd == CMD_START) begin
         factor_block(n);
         w.status = flags_now();
      end else if ((cmd inside {CMD_WRITE, CMD_READ}) && !in_range) begin
         w.status = ST_OUTSIDE;
      end else begin
         if (cmd == CMD_WRITE) begin
            lu_mat[r * 64 + c] = int'(v);
            lu_written[r * 64 + c] = 1'b1;
         end else if (cmd == CMD_READ) begin
            if (sel == 1'b0) begin
               w.data = (r >= c) ? lu_mat[r * 64 + c] : 0;
            end else if (r < c) begin
               w.data = lu_mat[r * 64 + c];
            end else if (r == c) begin
               w.data = ONE_VAL;
            end
         end
         w.status = flags_now();
      end
   endtask

   // Offer one word after a random gap; predict once it is taken.
   task automatic send_word(logic [1:0] cmd, int r, int c, logic [31:0] v, bit sel,
                            bit typed = 1'b0, logic [31:0] e_data = '0,
                            logic [1:0] e_status = ST_OK);
      int           gap;
      rsp_word_type w;
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, v, c[5:0], r[5:0]};
      req_tuser  <= {sel, cmd};
      do @(posedge clock); while (!req_tready);
      lu_predict(cmd, r, c, v, sel, w);
      if (typed) begin
         w.data = e_data;
         w.status = e_status;
      end
      pending_rsp_q.push_back(w);
      item_count++;
   endtask

   // Let the block drain, then write the order register.
   task automatic set_order(logic [6:0] v);
      req_tvalid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      order_reg = v;
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   // A random word that never reads or factors entries that were never written.
   task automatic send_noise();
      logic [1:0] cmd;
      int         r;
      int         c;
      int         n;
      cmd = 2'($urandom_range(0, 3));
      r = $urandom_range(0, 63);
      c = $urandom_range(0, 63);
      n = active_order();
      if (cmd == CMD_READ && r < n && c < n && !lu_written[r * 64 + c]) cmd = CMD_NONE;
      if (cmd == CMD_START && !block_written(n)) cmd = CMD_NONE;
      send_word(cmd, r, c, $urandom, 1'($urandom));
   endtask

   function automatic logic [31:0] entry_value(int mode, int r, int c);
      logic [31:0] mag;
      if (mode == 1) return $urandom;
      if (mode == 2 && r == 0 && c == 0) return '0;
      if (r == c) mag = 32'($urandom_range(2, 8)) << FRAC_BITS;
      else mag = 32'($urandom_range(0, 32'h10000));
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   // Fill a small block, factor it and read the factors back.
   task automatic small_session(logic [6:0] cfg, int mode);
      int n;
      int r;
      int c;
      set_order(cfg);
      n = active_order();
      for (int i = 0; i < n * n; i++) begin
         if ($urandom_range(0, 7) == 0) send_noise();
         send_word(CMD_WRITE, i / n, i % n, entry_value(mode, i / n, i % n), 1'($urandom));
      end
      send_word(CMD_START, $urandom_range(0, 63), $urandom_range(0, 63), $urandom, 1'($urandom));
      for (int i = 0; i < n * n + 2; i++) begin
         r = $urandom_range(0, n - 1);
         c = $urandom_range(0, n - 1);
         if ($urandom_range(0, 9) == 0) r = $urandom_range(n, 63);
         send_word(CMD_READ, r, c, $urandom, 1'($urandom));
         if ($urandom_range(0, 11) == 0) send_noise();
      end
      if ($urandom_range(0, 3) == 0) begin
         send_word(CMD_START, 0, 0, 0, 1'b0);
         send_word(CMD_READ, n - 1, n - 1, 0, 1'b0);
      end
   endtask

   // Writes and reads across the full index range, with no factorization.
   task automatic wide_session(logic [6:0] cfg);
      int addr_q [$];
      int a;
      set_order(cfg);
      for (int i = 0; i < 30; i++) begin
         a = $urandom_range(0, 1) ? $urandom_range(0, 4095) : 4095 - $urandom_range(0, 70);
         addr_q.push_back(a);
         send_word(CMD_WRITE, a / 64, a % 64, $urandom, 1'($urandom));
      end
      for (int i = 0; i < 30; i++) begin
         a = addr_q[$urandom_range(0, addr_q.size() - 1)];
         send_word(CMD_READ, a / 64, a % 64, $urandom, 1'($urandom));
         if ($urandom_range(0, 7) == 0) send_noise();
      end
   endtask

   // Directed table: typed results where they follow at a glance.
   dir_row_type dir_tab [22] = '{
      '{CMD_WRITE, 0, 0, 32'h7FFFFFFF, 0, 1, 0, ST_OK},
      '{CMD_WRITE, 1, 1, 32'h80000000, 0, 1, 0, ST_OK},
      '{CMD_WRITE, 0, 1, 32'h00000000, 1, 1, 0, ST_OK},
      '{CMD_WRITE, 1, 0, 32'h00010000, 0, 1, 0, ST_OK},
      '{CMD_WRITE, 2, 0, 32'h00000005, 0, 1, 0, ST_OUTSIDE},
      '{CMD_READ,  5, 5, 32'h0, 0, 1, 0, ST_OUTSIDE},
      '{CMD_READ,  0, 0, 32'h0, 0, 1, 32'h7FFFFFFF, ST_OK},
      '{CMD_READ,  1, 1, 32'h0, 1, 1, 32'h00010000, ST_OK},
      '{CMD_READ,  1, 0, 32'h0, 1, 1, 0, ST_OK},
      '{CMD_READ,  0, 1, 32'h0, 0, 1, 0, ST_OK},
      '{CMD_NONE,  3, 7, 32'hFFFFFFFF, 1, 1, 0, ST_OK},
      '{CMD_START, 0, 0, 32'h0, 0, 0, 0, ST_OK},
      '{CMD_READ,  1, 1, 32'h0, 0, 0, 0, ST_OK},
      '{CMD_WRITE, 0, 0, 32'h0, 0, 1, 0, ST_OK},
      '{CMD_START, 0, 0, 32'h0, 0, 1, 0, ST_ZERO_PIVOT},
      '{CMD_NONE,  0, 0, 32'h0, 0, 1, 0, ST_ZERO_PIVOT},
      '{CMD_READ,  0, 1, 32'h0, 1, 1, 0, ST_ZERO_PIVOT},
      '{CMD_WRITE, 0, 0, 32'h00000001, 0, 1, 0, ST_ZERO_PIVOT},
      '{CMD_WRITE, 0, 1, 32'h7FFFFFFF, 0, 1, 0, ST_ZERO_PIVOT},
      '{CMD_START, 0, 0, 32'h0, 0, 1, 0, ST_SATURATED},
      '{CMD_READ,  0, 1, 32'h0, 1, 1, 32'h7FFFFFFF, ST_SATURATED},
      '{CMD_READ,  1, 1, 32'h0, 0, 1, 32'h80000000, ST_SATURATED}
   };

   // Result side: random readiness, one long hold on request.
   initial begin
      int           gap;
      rsp_word_type w;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, 13);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (hold_cycles > 0) begin
            gap = hold_cycles;
            hold_cycles = 0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 0);
         end else begin
            w = pending_rsp_q.pop_front();
            if (rsp_tdata !== w.data) report_mismatch("read_value", rsp_tdata, w.data);
            if (rsp_tuser !== w.status) report_mismatch("status", 32'(rsp_tuser), 32'(w.status));
         end
      end
   end

   // Main sequence: reset, directed table, random sessions, drain.
   initial begin
      int session;
      int mode;
      for (int i = 0; i < 4096; i++) begin
         lu_mat[i] = 0;
         lu_written[i] = 1'b0;
      end
      pivot_zero = 1'b0;
      clipped = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Right after reset the full order is in use.
      send_word(CMD_READ, 63, 63, 0, 1'b1, 1'b1, ONE_VAL, ST_OK);
      set_order(7'd2);
      foreach (dir_tab[i])
         send_word(dir_tab[i].cmd, dir_tab[i].row, dir_tab[i].col, dir_tab[i].value,
                   dir_tab[i].sel, dir_tab[i].typed, dir_tab[i].exp_data,
                   dir_tab[i].exp_status);

      session = 0;
      while (item_count < ITEMS_WANTED) begin
         mode = $urandom_range(0, 9);
         mode = (mode < 7) ? 0 : (mode < 9) ? 1 : 2;
         if (session == 3) hold_cycles = 400;
         case (session % 9)
            2: begin
               wide_session(7'd64);
            end
            5: begin
               wide_session(7'd127);
            end
            7: begin
               small_session(7'd0, mode);
            end
            8: begin
               small_session(7'd8, mode);
            end
            default: begin
               small_session(7'($urandom_range(1, 6)), mode);
            end
         endcase
         session++;
      end

      req_tvalid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_crout_lu_decomposition: PASS");
      end else begin
         $display("tb_crout_lu_decomposition: FAIL");
      end
      $finish;
   end

endmodule
